[rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg - cuckoo hash table shared definitions
// Sizes, hash constants, status codes and the per-byte hash steps.
// ----------------------------------------------------------------------------
package cht_pkg;

	// Table geometry; SLOTS must be a power of two, so the slot index is
	// the low bits of each 64-bit hash.
	localparam int SLOTS     = 128;
	localparam int KEY_BYTES = 8;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int KICK_W    = $clog2(SLOTS + 1);
	localparam int BIDX_W    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
	localparam int KEY_W     = 64;
	localparam int VAL_W     = 32;
	localparam int OP_W      = 2;

	// Hash constants
	localparam int DJB2_INIT = 5381;
	localparam int DJB2_SH   = 5;
	localparam int SDBM_SH1  = 6;
	localparam int SDBM_SH2  = 16;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_REMOVE = 2'd2,
		OP_RSVD   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_MISS  = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]        key;
		logic signed [VAL_W-1:0] val;
	} entry_t;

	// One sdbm step on the low slot bits; the byte is sign-extended.
	function automatic logic [SLOT_W-1:0] sdbm_step(input logic [SLOT_W-1:0] h,
			input logic [7:0] b);
		logic [SLOT_W-1:0] sb;
		sb = SLOT_W'($signed(b));
		return sb + (h << SDBM_SH1) + (h << SDBM_SH2) - h;
	endfunction

	// One djb2 step on the low slot bits.
	function automatic logic [SLOT_W-1:0] djb2_step(input logic [SLOT_W-1:0] h,
			input logic [7:0] b);
		logic [SLOT_W-1:0] sb;
		sb = SLOT_W'($signed(b));
		return (h << DJB2_SH) + h + sb;
	endfunction

endpackage

[rtl/cuckoo_hash_table_top.sv]
// ----------------------------------------------------------------------------
// cuckoo_hash_table_top - two-choice cuckoo hash table
// Stores up to 128 short text keys with a 32-bit value each.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat (op, key, value) is taken when in_valid is high and in_stall
//   low. in_stall is high while an operation is in flight. One result beat
//   (status, value_out, slot_used, homeless_key, homeless_value) follows on
//   the output channel for every input beat.
// Sequence:
//   An empty key goes straight to the result. Otherwise the key is hashed
//   one byte per cycle (up to 8 bytes), then each candidate slot is read
//   and checked on the single table read port, for lookup, remove and
//   insert into a free slot. Each eviction kick adds a read/swap, a rehash
//   of the evicted key and a probe of its other slot; a chain stops after
//   128 kicks.
// Throughput:
//   One beat at a time; the next beat is taken in the cycle after the result
//   is loaded into the output register.
// Reset:
//   arst_n clears every slot valid bit at once, so the table reads empty
//   immediately; the block is ready as soon as reset is released.
// Stall:
//   The result is held in an output register until taken; the next beat may
//   be accepted meanwhile, but its result waits for the register to free.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [cht_pkg::OP_W-1:0]         op,
	input  logic [cht_pkg::KEY_W-1:0]        key,
	input  logic signed [cht_pkg::VAL_W-1:0] value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic signed [cht_pkg::VAL_W-1:0] value_out,
	output logic [cht_pkg::SLOT_W-1:0]       slot_used,
	output logic [cht_pkg::KEY_W-1:0]        homeless_key,
	output logic signed [cht_pkg::VAL_W-1:0] homeless_value
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_HASH  = 11'b000_0000_0010,
		S_RD1   = 11'b000_0000_0100,
		S_CHK1  = 11'b000_0000_1000,
		S_RD2   = 11'b000_0001_0000,
		S_CHK2  = 11'b000_0010_0000,
		S_KRD   = 11'b000_0100_0000,
		S_KSWAP = 11'b000_1000_0000,
		S_ARD   = 11'b001_0000_0000,
		S_ACHK  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Operation registers
	cht_pkg::op_t                       op_q;
	logic [cht_pkg::KEY_W-1:0]          key_q;
	logic signed [cht_pkg::VAL_W-1:0]   val_q;
	logic [cht_pkg::SLOT_W-1:0]         s1_q, s2_q, pos_q, alt_q;
	logic [cht_pkg::KICK_W-1:0]         kicks_q;
	logic [cht_pkg::KEY_W-1:0]          pend_key_q;
	logic signed [cht_pkg::VAL_W-1:0]   pend_val_q;
	logic                               evict_q;

	// Hash unit registers
	logic [cht_pkg::KEY_W-1:0]          hkey_q;
	logic [cht_pkg::BIDX_W-1:0]         bidx_q;
	logic [cht_pkg::SLOT_W-1:0]         h1_q, h2_q;

	// Result registers
	cht_pkg::status_t                   res_status_q;
	logic signed [cht_pkg::VAL_W-1:0]   res_val_q;
	logic [cht_pkg::SLOT_W-1:0]         res_slot_q;
	logic [cht_pkg::KEY_W-1:0]          res_hkey_q;
	logic signed [cht_pkg::VAL_W-1:0]   res_hval_q;

	// Output registers
	logic                               out_valid_q;
	cht_pkg::status_t                   out_status_q;
	logic signed [cht_pkg::VAL_W-1:0]   out_val_q;
	logic [cht_pkg::SLOT_W-1:0]         out_slot_q;
	logic [cht_pkg::KEY_W-1:0]          out_hkey_q;
	logic signed [cht_pkg::VAL_W-1:0]   out_hval_q;

	// Table storage
	cht_pkg::entry_t                    mem [cht_pkg::SLOTS];
	logic [cht_pkg::SLOTS-1:0]          valid_q;
	cht_pkg::entry_t                    rd_entry_q;
	logic                               rd_valid_q;

	logic                               in_fire;
	logic                               out_load;
	logic [cht_pkg::KEY_W-1:0]          key_norm;
	logic [7:0]                         cur_byte;
	logic                               hash_done;
	logic [cht_pkg::SLOT_W-1:0]         h1_nx, h2_nx;
	logic [cht_pkg::SLOT_W-1:0]         rd_addr;
	logic                               wr_en;
	logic [cht_pkg::SLOT_W-1:0]         wr_addr;
	cht_pkg::entry_t                    wr_data;
	logic                               vclr_en;
	logic [cht_pkg::KEY_W-1:0]          rd_key;
	logic signed [cht_pkg::VAL_W-1:0]   rd_val;
	logic                               hit;

	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	// Normalize: drop every byte from the first zero byte on
	always_comb begin
		logic alive;
		alive    = 1'b1;
		key_norm = '0;
		for (int i = 0; i < 8; i++) begin
			if (key[8*i +: 8] == 8'd0 || i >= cht_pkg::KEY_BYTES) alive = 1'b0;
			if (alive) key_norm[8*i +: 8] = key[8*i +: 8];
		end
	end

	// Hash unit: one byte per cycle, both hashes side by side
	assign cur_byte  = hkey_q[8*bidx_q +: 8];
	assign h1_nx     = (cur_byte != 8'd0) ? cht_pkg::sdbm_step(h1_q, cur_byte) : h1_q;
	assign h2_nx     = (cur_byte != 8'd0) ? cht_pkg::djb2_step(h2_q, cur_byte) : h2_q;
	assign hash_done = (cur_byte == 8'd0) ||
		(bidx_q == cht_pkg::BIDX_W'(cht_pkg::KEY_BYTES - 1));

	// Read port address
	always_comb begin
		unique case (state_q)
			S_RD1:   rd_addr = s1_q;
			S_RD2:   rd_addr = s2_q;
			S_KRD:   rd_addr = pos_q;
			S_ARD:   rd_addr = alt_q;
			default: rd_addr = s1_q;
		endcase
	end

	// Invalid slots read as vacant with value minus one
	assign rd_key = rd_valid_q ? rd_entry_q.key : '0;
	assign rd_val = rd_valid_q ? rd_entry_q.val : '1;
	assign hit    = rd_valid_q && (rd_entry_q.key == key_q);

	// Write port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = s1_q;
		wr_data = '{key: key_q, val: val_q};
		vclr_en = 1'b0;
		unique case (state_q)
			S_CHK1: begin
				if (op_q == cht_pkg::OP_INSERT) begin
					wr_en = !rd_valid_q;
				end else if (op_q == cht_pkg::OP_REMOVE) begin
					vclr_en = hit;
				end
			end
			S_CHK2: begin
				wr_addr = s2_q;
				if (op_q == cht_pkg::OP_INSERT) begin
					wr_en = !rd_valid_q;
				end else if (op_q == cht_pkg::OP_REMOVE) begin
					vclr_en = hit;
				end
			end
			S_KSWAP: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = '{key: pend_key_q, val: pend_val_q};
			end
			S_ACHK: begin
				wr_en   = !rd_valid_q;
				wr_addr = alt_q;
				wr_data = '{key: pend_key_q, val: pend_val_q};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Table memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_entry_q <= mem[rd_addr];
	end

	// Slot valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			rd_valid_q <= valid_q[rd_addr];
			if (wr_en) valid_q[wr_addr] <= 1'b1;
			if (vclr_en) valid_q[wr_addr] <= 1'b0;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			evict_q <= 1'b0;
			kicks_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						op_q    <= cht_pkg::op_t'(op);
						key_q   <= key_norm;
						val_q   <= value;
						hkey_q  <= key_norm;
						bidx_q  <= '0;
						h1_q    <= '0;
						h2_q    <= cht_pkg::SLOT_W'(cht_pkg::DJB2_INIT);
						evict_q <= 1'b0;
						kicks_q <= '0;
						res_val_q  <= (key_norm == '0) ? '1 : value;
						res_slot_q <= '0;
						res_hkey_q <= '0;
						res_hval_q <= '0;
						if (key_norm == '0) begin
							res_status_q <= cht_pkg::ST_EMPTY;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					h1_q   <= h1_nx;
					h2_q   <= h2_nx;
					bidx_q <= bidx_q + 1'b1;
					if (hash_done) begin
						if (evict_q) begin
							alt_q   <= (h1_nx == pos_q) ? h2_nx : h1_nx;
							state_q <= S_ARD;
						end else begin
							s1_q    <= h1_nx;
							s2_q    <= h2_nx;
							state_q <= S_RD1;
						end
					end
				end
				S_RD1: state_q <= S_CHK1;
				S_CHK1: begin
					if (op_q == cht_pkg::OP_INSERT) begin
						if (!rd_valid_q) begin
							res_status_q <= cht_pkg::ST_OK;
							res_slot_q   <= s1_q;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_RD2;
						end
					end else if (hit) begin
						res_status_q <= cht_pkg::ST_OK;
						res_val_q    <= rd_val;
						res_slot_q   <= s1_q;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD2: state_q <= S_CHK2;
				S_CHK2: begin
					if (op_q == cht_pkg::OP_INSERT) begin
						if (!rd_valid_q) begin
							res_status_q <= cht_pkg::ST_OK;
							res_slot_q   <= s2_q;
							state_q      <= S_DONE;
						end else begin
							// both occupied: start the eviction chain at the first slot
							pend_key_q <= key_q;
							pend_val_q <= val_q;
							pos_q      <= s1_q;
							res_slot_q <= s1_q;
							state_q    <= S_KRD;
						end
					end else if (hit) begin
						res_status_q <= cht_pkg::ST_OK;
						res_val_q    <= rd_val;
						res_slot_q   <= s2_q;
						state_q      <= S_DONE;
					end else begin
						res_status_q <= cht_pkg::ST_MISS;
						res_val_q    <= '1;
						state_q      <= S_DONE;
					end
				end
				S_KRD: state_q <= S_KSWAP;
				S_KSWAP: begin
					// swap pending entry in, rehash the one kicked out
					pend_key_q <= rd_key;
					pend_val_q <= rd_val;
					kicks_q    <= kicks_q + 1'b1;
					hkey_q     <= rd_key;
					bidx_q     <= '0;
					h1_q       <= '0;
					h2_q       <= cht_pkg::SLOT_W'(cht_pkg::DJB2_INIT);
					evict_q    <= 1'b1;
					state_q    <= S_HASH;
				end
				S_ARD: state_q <= S_ACHK;
				S_ACHK: begin
					if (!rd_valid_q) begin
						res_status_q <= cht_pkg::ST_OK;
						state_q      <= S_DONE;
					end else if (kicks_q == cht_pkg::KICK_W'(cht_pkg::SLOTS)) begin
						res_status_q <= cht_pkg::ST_FULL;
						res_hkey_q   <= pend_key_q;
						res_hval_q   <= pend_val_q;
						state_q      <= S_DONE;
					end else begin
						pos_q   <= alt_q;
						state_q <= S_KRD;
					end
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register: load a finished beat, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
			out_slot_q   <= res_slot_q;
			out_hkey_q   <= res_hkey_q;
			out_hval_q   <= res_hval_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign value_out      = out_val_q;
	assign slot_used      = out_slot_q;
	assign homeless_key   = out_hkey_q;
	assign homeless_value = out_hval_q;

`ifndef NO_ASSERTIONS
	a_kick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kicks_q <= cht_pkg::KICK_W'(cht_pkg::SLOTS))
		else $error("eviction chain exceeded the kick limit");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q != S_IDLE))
		else $error("accepted beat did not start an operation");

	a_full_homeless: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == cht_pkg::ST_FULL) |-> (homeless_key != '0))
		else $error("full status without a homeless key");

	a_no_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && vclr_en))
		else $error("slot written and cleared in the same cycle");

	a_write_target: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr == s1_q || wr_addr == s2_q || wr_addr == pos_q ||
			wr_addr == alt_q))
		else $error("table write to an unrelated slot");
`endif

endmodule

[test/cuckoo_hash_table_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_top_test - self-checking bench for the cuckoo hash table
// Drives insert, lookup, remove and reserved-op beats with random idle cycles on both
// channels. A behavioral copy of the table predicts each result beat, and
// the checker compares every field with the oldest prediction.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_top_test;

	typedef struct {
		cht_pkg::status_t           st;
		logic signed [31:0]         vout;
		logic [cht_pkg::SLOT_W-1:0] slot;
		logic [63:0]                hkey;
		logic signed [31:0]         hval;
	} answer_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [cht_pkg::OP_W-1:0] op;
	logic [cht_pkg::KEY_W-1:0] key;
	logic signed [cht_pkg::VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic [1:0] status;
	logic signed [cht_pkg::VAL_W-1:0] value_out;
	logic [cht_pkg::SLOT_W-1:0] slot_used;
	logic [cht_pkg::KEY_W-1:0] homeless_key;
	logic signed [cht_pkg::VAL_W-1:0] homeless_value;

	// predicted table contents
	logic [63:0] tbl_key[cht_pkg::SLOTS];
	logic [31:0] tbl_val[cht_pkg::SLOTS];
	answer_t answers[$];
	logic [63:0] known_keys[$];
	int errors;
	bit idle_on;
	bit hold_out;

	cuckoo_hash_table_top DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#200ms;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [63:0] clean_key(logic [63:0] k);
		logic [63:0] r;
		r = 0;
		for (int i = 0; i < cht_pkg::KEY_BYTES; i++) begin
			if (k[8*i +: 8] == 0) break;
			r[8*i +: 8] = k[8*i +: 8];
		end
		return r;
	endfunction

	// sdbm when second is 0, djb2 otherwise
	function automatic int home_slot(logic [63:0] k, bit second);
		logic [63:0] h, b;
		h = second ? 64'd5381 : 64'd0;
		for (int i = 0; i < 8; i++) begin
			if (k[8*i +: 8] == 0) break;
			b = {{56{k[8*i+7]}}, k[8*i +: 8]};
			if (second) h = (h << 5) + h + b;
			else h = b + (h << 6) + (h << 16) - h;
		end
		return int'(h % cht_pkg::SLOTS);
	endfunction

	function automatic answer_t predict(logic [1:0] o, logic [63:0] k_in,
			logic [31:0] v);
		answer_t a;
		logic [63:0] k, tk, pk;
		logic [31:0] tv, pv;
		int s1, s2, pos, alt, hit;
		bit placed;
		a = '{cht_pkg::ST_OK, 32'sd0, '0, 64'd0, 32'sd0};
		k = clean_key(k_in);
		if (k == 0) begin
			a.st = cht_pkg::ST_EMPTY;
			a.vout = -1;
			return a;
		end
		s1 = home_slot(k, 0);
		s2 = home_slot(k, 1);
		if (o == cht_pkg::OP_INSERT) begin
			a.vout = v;
			if (tbl_key[s1] == 0) begin
				tbl_key[s1] = k; tbl_val[s1] = v; a.slot = s1;
			end else if (tbl_key[s2] == 0) begin
				tbl_key[s2] = k; tbl_val[s2] = v; a.slot = s2;
			end else begin
				// walk the eviction chain
				pos = s1; pk = k; pv = v; placed = 0; a.slot = s1;
				for (int n = 0; n < cht_pkg::SLOTS; n++) begin
					tk = tbl_key[pos]; tv = tbl_val[pos];
					tbl_key[pos] = pk; tbl_val[pos] = pv;
					pk = tk; pv = tv;
					alt = home_slot(tk, 0);
					if (alt == pos) alt = home_slot(tk, 1);
					if (tbl_key[alt] == 0) begin
						tbl_key[alt] = pk; tbl_val[alt] = pv;
						placed = 1;
						break;
					end
					pos = alt;
				end
				if (!placed) begin
					a.st = cht_pkg::ST_FULL; a.hkey = pk; a.hval = pv;
				end
			end
		end else begin
			hit = -1;
			if (tbl_key[s1] == k) hit = s1;
			else if (tbl_key[s2] == k) hit = s2;
			if (hit < 0) begin
				a.st = cht_pkg::ST_MISS; a.vout = -1;
			end else begin
				a.slot = hit; a.vout = tbl_val[hit];
				if (o == cht_pkg::OP_REMOVE) begin
					tbl_key[hit] = 0; tbl_val[hit] = '1;
				end
			end
		end
		return a;
	endfunction

	// Send one beat and log its prediction; valid stays up until the next
	// idle cycle or drain
	task automatic send_beat(logic [1:0] o, logic [63:0] k, logic [31:0] v);
		while (idle_on && $urandom_range(99) < 29) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; op <= o; key <= k; value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		answers.push_back(predict(o, k, v));
		if (clean_key(k) != 0 && known_keys.size() < 300) known_keys.push_back(k);
	endtask

	// Stop offering beats and wait for every expected result
	task automatic drain;
		in_valid <= 0;
		while (answers.size() != 0) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_text(int len);
		logic [63:0] k;
		k = 0;
		for (int i = 0; i < len; i++) k[8*i +: 8] = 8'($urandom_range(255, 1));
		return k;
	endfunction

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		answer_t a;
		if (arst_n && out_valid && !out_stall) begin
			if (answers.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				a = answers.pop_front();
				if (status !== a.st) begin
					$error("status exp %0d got %0d", a.st, status); errors++;
				end
				if (value_out !== a.vout) begin
					$error("value_out exp %0d got %0d", a.vout, value_out); errors++;
				end
				if (slot_used !== a.slot) begin
					$error("slot_used exp %0d got %0d", a.slot, slot_used); errors++;
				end
				if (homeless_key !== a.hkey) begin
					$error("homeless_key exp %h got %h", a.hkey, homeless_key); errors++;
				end
				if (homeless_value !== a.hval) begin
					$error("homeless_value exp %0d got %0d", a.hval, homeless_value);
					errors++;
				end
			end
		end
	end

	// Receiver idling, with a long hold-off on request
	initial begin
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				out_stall <= 0;
				hold_out = 0;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < 29);
			end
		end
	end

	task automatic test_directed;
		send_beat(cht_pkg::OP_INSERT, 64'h0, 32'd5);
		send_beat(cht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FF00, 32'd0);
		send_beat(cht_pkg::OP_INSERT, 64'h61, 32'h7FFF_FFFF);
		send_beat(cht_pkg::OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h8000_0000);
		send_beat(cht_pkg::OP_INSERT, 64'h0000_0000_0000_0080, 32'hFFFF_FFFF);
		send_beat(cht_pkg::OP_LOOKUP, 64'h61, 32'd0);
		send_beat(cht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send_beat(cht_pkg::OP_RSVD, 64'h80, 32'd0);
		send_beat(cht_pkg::OP_LOOKUP, 64'h62, 32'd0);
		// bytes past a zero byte are ignored
		send_beat(cht_pkg::OP_INSERT, 64'hAA55_0000_0000_6364, 32'd77);
		send_beat(cht_pkg::OP_LOOKUP, 64'h0000_0000_0000_6364, 32'd0);
		send_beat(cht_pkg::OP_REMOVE, 64'h61, 32'd0);
		send_beat(cht_pkg::OP_REMOVE, 64'h61, 32'd0);
		send_beat(cht_pkg::OP_LOOKUP, 64'h61, 32'd0);
		send_beat(cht_pkg::OP_INSERT, 64'h61, 32'd1);
		send_beat(cht_pkg::OP_INSERT, 64'h61, 32'd2);
		send_beat(cht_pkg::OP_REMOVE, 64'hFF00_0000_0000_0000, 32'd0);
		drain();
	endtask

	// Fill the table far enough to drive eviction chains and full reports
	task automatic test_fill;
		for (int i = 0; i < 200; i++)
			send_beat(cht_pkg::OP_INSERT, rand_text(int'($urandom_range(3, 1))),
				$urandom);
		drain();
	endtask

	task automatic test_random;
		logic [63:0] k;
		int r;
		for (int i = 0; i < 230; i++) begin
			if (i == 40) idle_on = 0;
			if (i == 90) idle_on = 1;
			if (i == 120) hold_out = 1;
			if (i == 170) drain();
			r = int'($urandom_range(99));
			if (r < 5) k = {$urandom, $urandom};
			else if (r < 55 && known_keys.size() > 0)
				k = known_keys[$urandom_range(known_keys.size() - 1)];
			else k = rand_text(int'($urandom_range(8, 1)));
			send_beat(2'($urandom_range(3)), k, $urandom);
		end
		drain();
	endtask

	initial begin
		errors = 0;
		idle_on = 1;
		hold_out = 0;
		arst_n = 0;
		in_valid = 0;
		op = cht_pkg::OP_INSERT;
		key = 0;
		value = 0;
		for (int i = 0; i < cht_pkg::SLOTS; i++) begin
			tbl_key[i] = 0;
			tbl_val[i] = '1;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_fill();
		test_random();
		repeat (50) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
